@@ design/ofe_pkg.sv @@
package ofe_pkg;

  localparam int FADE_SLOTS      = 16;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int SLOT_W          = $clog2(FADE_SLOTS);
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int STEP_W          = LEVEL_W + 1;
  localparam int STEPS_W         = LEVEL_W + 1;

  localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [2:0] EV_LEVEL    = 3'd0;
  localparam logic [2:0] EV_FINISHED = 3'd1;
  localparam logic [2:0] EV_CALLBACK = 3'd2;
  localparam logic [2:0] EV_FULL     = 3'd3;
  localparam logic [2:0] EV_WAIT     = 3'd4;

  typedef struct packed {
    logic [31:0]              window;
    logic [LEVEL_W-1:0]       level;
    logic [LEVEL_W-1:0]       target;
    logic signed [STEP_W-1:0] step;
    logic [7:0]               callback;
  } slot_t;

endpackage

@@ design/ofe_slot_ram.sv @@
module ofe_slot_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ofe_pkg::SLOT_W-1:0] waddr_i,
  input  ofe_pkg::slot_t            wdata_i,
  input  logic [ofe_pkg::SLOT_W-1:0] raddr_i,
  output ofe_pkg::slot_t            rdata_o
);
  import ofe_pkg::*;

  slot_t mem [FADE_SLOTS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ofe_div.sv @@
module ofe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import ofe_pkg::*;

  logic [16:0] rem_q;
  logic [31:0] quot_q;
  logic [15:0] div_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [16:0] trial;
  logic [16:0] rem_sh;

  assign rem_sh = {rem_q[15:0], quot_q[31]};
  assign trial  = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_q  <= trial;
        quot_q <= {quot_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/opacity_fade_engine_unit.sv @@
// Opacity fade engine: a table of per-window opacity ramps (Q16 levels).
// Input items arrive on the s_* stream: s_tuser is the request type (set,
// cancel, tick, query), s_tdata holds the request fields. Results leave on
// the m_* stream with m_tuser as event kind and m_tlast on the last result
// of a request. The user must write tick_period_ms over the APB port only
// while idle; the block does not enforce this. One request is handled at a
// time. Set and cancel walk the slot memory slot by slot to find the
// window. A due tick runs a bit-serial divide for the elapsed step count,
// then reads, multiplies and writes back each used slot, skips free slots,
// then gives the wait report. Query and not-due ticks go to the wait report.
// Slot data lives in a single-port-write, registered-read memory; the used
// flags and next tick time are flops. Reset clears all used flags, sets the
// period to 10 ms and next tick time to 0; no clearing pass is needed.
// A stalled receiver holds the output register; the engine waits on it and
// takes a new item as soon as it is back in idle, even with a result held.
module opacity_fade_engine_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] window_id, [63:32] now_ms, [80:64] start_level,
  // [99:81] finish_level, [116:100] step_size, [124:117] callback_tag,
  // [125] run_old_callback, [126] override_existing, [127] zero
  input  logic [127:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] window_id_out, [48:32] opacity_level, [56:49] callback_out,
  // [73:57] wait_ms, [79:74] zero
  output logic [79:0]  m_tdata,
  // [2:0] event_kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ofe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_CMP, S_DECIDE, S_OVR_UPD, S_DIV,
    S_TRD, S_TMUL, S_TAPPLY, S_TFIN, S_WAIT
  } state_e;

  state_e state_q;

  logic [15:0] period_q;
  logic [15:0] p_eff;
  logic [FADE_SLOTS-1:0] used_q;
  logic [31:0] next_tick_q;

  logic [1:0]  req_q;
  logic [31:0] win_q;
  logic [31:0] now_q;
  logic [LEVEL_W-1:0] start_q;
  logic signed [18:0] fin_q;
  logic [LEVEL_W-1:0] step_q;
  logic [7:0]  cb_q;
  logic        run_old_q;
  logic        over_q;

  logic [SLOT_W-1:0] idx_q;
  logic        hit_q;
  slot_t       ent_q;
  logic [STEPS_W-1:0] steps_q;
  logic signed [STEP_W+STEPS_W:0] prod_q;

  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [31:0] out_win_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic [7:0]  out_cb_q;
  logic [16:0] out_wait_q;
  logic        out_last_q;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        in_due;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quot;
  logic        ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_raddr;
  slot_t       ram_wdata;
  slot_t       ram_rdata;

  logic [SLOT_W-1:0] free_idx;
  logic        free_any;
  logic [LEVEL_W-1:0] fin_clamp;
  logic [LEVEL_W-1:0] base_level;
  logic signed [STEP_W-1:0] new_step;
  slot_t       set_entry;
  logic signed [STEP_W+STEPS_W+1:0] cur_wide;
  logic [LEVEL_W-1:0] cur_level;
  logic        tick_done;
  logic signed [31:0] wait_diff;
  logic [16:0] wait_val;
  logic [32:0] steps_wide;
  logic        last_idx;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FADE_SLOTS - 1);

  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {16'd0, period_q};
  assign p_eff    = (period_q == 16'd0) ? 16'd1 : period_q;
  assign s_tready = (state_q == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid_q || m_tready;
  assign last_idx = (idx_q == LAST_SLOT);
  assign in_due   = !($signed(next_tick_q - s_tdata[63:32]) > 32'sd0);
  assign div_start = accept && (s_tuser == REQ_TICK) && in_due;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = FADE_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    if (fin_q < 19'sd0) begin
      fin_clamp = '0;
    end else if (fin_q > $signed({2'b00, ONE_LEVEL})) begin
      fin_clamp = ONE_LEVEL;
    end else begin
      fin_clamp = fin_q[LEVEL_W-1:0];
    end
    if (hit_q) begin
      base_level = ent_q.level;
    end else begin
      base_level = (start_q > ONE_LEVEL) ? ONE_LEVEL : start_q;
    end
    if (base_level < fin_clamp) begin
      new_step = $signed({1'b0, step_q});
    end else if (base_level > fin_clamp) begin
      new_step = -$signed({1'b0, step_q});
    end else begin
      new_step = hit_q ? ent_q.step : '0;
    end
    set_entry.window   = win_q;
    set_entry.level    = base_level;
    set_entry.target   = fin_clamp;
    set_entry.step     = new_step;
    set_entry.callback = cb_q;
  end

  always_comb begin
    cur_wide = $signed({{(STEP_W+STEPS_W+2-LEVEL_W){1'b0}}, ent_q.level}) +
               (STEP_W+STEPS_W+2)'(prod_q);
    if (cur_wide >= $signed({{(STEP_W+STEPS_W+2-LEVEL_W){1'b0}}, ONE_LEVEL})) begin
      cur_level = ONE_LEVEL;
    end else if (cur_wide < 0) begin
      cur_level = '0;
    end else begin
      cur_level = cur_wide[LEVEL_W-1:0];
    end
    if (ent_q.step > 0) begin
      tick_done = (cur_level >= ent_q.target);
    end else begin
      tick_done = (cur_level <= ent_q.target);
    end
  end

  always_comb begin
    wait_diff = $signed(next_tick_q - now_q);
    if (used_q == '0) begin
      wait_val = '1;
    end else if (wait_diff < 32'sd0) begin
      wait_val = '0;
    end else if (wait_diff > 32'sd65535) begin
      wait_val = 17'd65535;
    end else begin
      wait_val = wait_diff[16:0];
    end
  end

  // output register takes a new result this cycle
  always_comb begin
    out_load = 1'b0;
    case (state_q)
      S_DECIDE: begin
        if (req_q == REQ_CANCEL) begin
          out_load = hit_q && out_free;
        end else if (!hit_q) begin
          out_load = out_free;
        end else begin
          out_load = over_q && run_old_q && (ent_q.callback != 8'd0) && out_free;
        end
      end
      S_OVR_UPD, S_TAPPLY, S_WAIT: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign steps_wide = {1'b0, div_quot} + 33'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_q ? idx_q : free_idx;
    ram_wdata = set_entry;
    ram_raddr = idx_q;
    case (state_q)
      S_DECIDE: begin
        ram_we = (req_q == REQ_SET) && !hit_q && free_any && out_free;
      end
      S_OVR_UPD: begin
        ram_we = out_free;
      end
      S_TAPPLY: begin
        ram_we          = out_free;
        ram_waddr       = idx_q;
        ram_wdata       = ent_q;
        ram_wdata.level = cur_level;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ofe_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ofe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_tdata[63:32] - next_tick_q),
    .divisor_i  (p_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= 16'd10;
      used_q      <= '0;
      next_tick_q <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        period_q <= pwdata[15:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q     <= s_tuser;
            win_q     <= s_tdata[31:0];
            now_q     <= s_tdata[63:32];
            start_q   <= s_tdata[80:64];
            fin_q     <= s_tdata[99:81];
            step_q    <= s_tdata[116:100];
            cb_q      <= s_tdata[124:117];
            run_old_q <= s_tdata[125];
            over_q    <= s_tdata[126];
            idx_q     <= '0;
            hit_q     <= 1'b0;
            if (s_tuser == REQ_SET || s_tuser == REQ_CANCEL) begin
              state_q <= S_LOOK;
            end else if (div_start) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_WAIT;
            end
          end
        end
        S_LOOK: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (used_q[idx_q] && ram_rdata.window == win_q) begin
            hit_q   <= 1'b1;
            ent_q   <= ram_rdata;
            state_q <= S_DECIDE;
          end else if (last_idx) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q   <= idx_q + SLOT_W'(1);
            state_q <= S_LOOK;
          end
        end
        S_DECIDE: begin
          if (req_q == REQ_CANCEL) begin
            if (!hit_q) begin
              state_q <= S_IDLE;
            end else if (out_free) begin
              used_q[idx_q] <= 1'b0;
              out_kind_q    <= EV_FINISHED;
              out_win_q     <= win_q;
              out_level_q   <= ent_q.level;
              out_cb_q      <= ent_q.callback;
              out_wait_q    <= '0;
              out_last_q    <= 1'b1;
              state_q       <= S_IDLE;
            end
          end else if (!hit_q) begin
            if (out_free) begin
              out_win_q   <= win_q;
              out_cb_q    <= '0;
              out_wait_q  <= '0;
              out_last_q  <= 1'b1;
              if (!free_any) begin
                out_kind_q  <= EV_FULL;
                out_level_q <= '0;
              end else begin
                if (used_q == '0) begin
                  next_tick_q <= now_q + {16'd0, p_eff};
                end
                used_q[free_idx] <= 1'b1;
                out_kind_q  <= EV_LEVEL;
                out_level_q <= base_level;
              end
              state_q <= S_IDLE;
            end
          end else if (!over_q) begin
            state_q <= S_IDLE;
          end else if (run_old_q && ent_q.callback != 8'd0) begin
            if (out_free) begin
              out_kind_q  <= EV_CALLBACK;
              out_win_q   <= win_q;
              out_level_q <= ent_q.level;
              out_cb_q    <= ent_q.callback;
              out_wait_q  <= '0;
              out_last_q  <= 1'b0;
              state_q     <= S_OVR_UPD;
            end
          end else begin
            state_q <= S_OVR_UPD;
          end
        end
        S_OVR_UPD: begin
          if (out_free) begin
            out_kind_q  <= EV_LEVEL;
            out_win_q   <= win_q;
            out_level_q <= base_level;
            out_cb_q    <= '0;
            out_wait_q  <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            steps_q <= (steps_wide[32:STEPS_W] != '0) ? '1 : steps_wide[STEPS_W-1:0];
            idx_q   <= '0;
            state_q <= S_TRD;
          end
        end
        S_TRD: begin
          if (used_q[idx_q]) begin
            state_q <= S_TMUL;
          end else if (last_idx) begin
            state_q <= S_TFIN;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        S_TMUL: begin
          ent_q   <= ram_rdata;
          prod_q  <= ram_rdata.step * $signed({1'b0, steps_q});
          state_q <= S_TAPPLY;
        end
        S_TAPPLY: begin
          if (out_free) begin
            out_win_q   <= ent_q.window;
            out_wait_q  <= '0;
            out_last_q  <= 1'b0;
            if (tick_done) begin
              used_q[idx_q] <= 1'b0;
              out_kind_q    <= EV_FINISHED;
              out_level_q   <= ent_q.target;
              out_cb_q      <= ent_q.callback;
            end else begin
              out_kind_q  <= EV_LEVEL;
              out_level_q <= cur_level;
              out_cb_q    <= '0;
            end
            if (last_idx) begin
              state_q <= S_TFIN;
            end else begin
              idx_q   <= idx_q + SLOT_W'(1);
              state_q <= S_TRD;
            end
          end
        end
        S_TFIN: begin
          next_tick_q <= now_q + {16'd0, p_eff};
          state_q     <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            out_kind_q  <= EV_WAIT;
            out_win_q   <= '0;
            out_level_q <= '0;
            out_cb_q    <= '0;
            out_wait_q  <= wait_val;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = out_kind_q;
  assign m_tlast  = out_last_q;
  assign m_tdata  = {6'd0, out_wait_q, out_cb_q, out_level_q, out_win_q};

endmodule
